/* rtl/core/rrwt_pkg.sv */
// Shared types and constants for the record request window tracker.
// No dependencies; every other file of the block refers to this package by scoped names.
package rrwt_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int OPCODE_W = 3;
  localparam int REC_W    = 11;
  localparam int WIN_W    = 7;
  localparam int RETRY_W  = 8;
  localparam int STAMP_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [OPCODE_W-1:0] OP_INIT    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_NEXT    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_RECV    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREREAD_COUNT = 2'd2;

  localparam logic [REC_W-1:0] RECORD_COUNT_RST  = 11'd1024;
  localparam logic [WIN_W-1:0] WINDOW_MAX_RST    = 7'd8;
  localparam logic [REC_W-1:0] PREREAD_COUNT_RST = 11'd0;

  localparam logic [STAMP_W-1:0] SLOT_NOT_SENT = 32'hFFFF_FFFF;
  localparam logic [STAMP_W-1:0] SLOT_RECEIVED = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    RANGE_GAP    = 2'd0,
    RANGE_ALL    = 2'd1,
    RANGE_BOTTOM = 2'd2
  } scan_range_t;

  typedef struct packed {
    logic        accept;
    logic        init_start;
    logic        fill;
    logic        scan_setup;
    scan_range_t range;
    logic        scan;
    logic        scan_bottom;
    logic        req_new;
    logic        rcv_start;
    logic        rcv_mark;
    logic        timeout;
    logic        clear;
    logic        out_load;
  } rrwt_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                req_ok;
    logic                gap;
    logic                top_lt_last;
    logic                inited;
    logic                in_range;
    logic                fill_last;
    logic                scan_stop;
    logic                scan_done;
    logic                bottom_le_idx;
  } rrwt_sts_t;

endpackage

/* rtl/core/rrwt_ifs.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on rrwt_pkg for the payload widths.
interface rrwt_req_if;
  logic                          valid;
  logic                          ready;
  logic [rrwt_pkg::OPCODE_W-1:0] opcode;
  logic [rrwt_pkg::REC_W-1:0]    record_number;

  modport source(output valid, output opcode, output record_number, input ready);
  modport sink(input valid, input opcode, input record_number, output ready);
endinterface

interface rrwt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         send_valid;
  logic [rrwt_pkg::REC_W-1:0]   send_record;
  logic                         send_another;
  logic                         new_data;
  logic                         all_received;
  logic [rrwt_pkg::RETRY_W-1:0] retry_count;
  logic                         ready_flag;

  modport source(output valid, output send_valid, output send_record, output send_another,
                 output new_data, output all_received, output retry_count,
                 output ready_flag, input ready);
  modport sink(input valid, input send_valid, input send_record, input send_another,
               input new_data, input all_received, input retry_count,
               input ready_flag, output ready);
endinterface

/* rtl/core/rrwt_ctrl.sv */
// Sequencing state machine of the tracker: decodes each transaction and steps the datapath.
// Depends on rrwt_pkg for the command and status structs and the opcodes.
module rrwt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rrwt_pkg::rrwt_sts_t sts,
  output rrwt_pkg::rrwt_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_FILL     = 10'b00_0000_0100,
    S_REQ_NEW  = 10'b00_0000_1000,
    S_REQ_ALT  = 10'b00_0001_0000,
    S_SCAN_GAP = 10'b00_0010_0000,
    S_SCAN_ALL = 10'b00_0100_0000,
    S_RCV_MARK = 10'b00_1000_0000,
    S_SCAN_BOT = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          rrwt_pkg::OP_INIT: begin
            cmd.init_start = 1'b1;
            state_next     = S_FILL;
          end
          rrwt_pkg::OP_NEXT: begin
            if (!sts.req_ok) begin
              state_next = S_FINISH;
            end else if (sts.gap) begin
              cmd.scan_setup = 1'b1;
              cmd.range      = rrwt_pkg::RANGE_GAP;
              state_next     = S_SCAN_GAP;
            end else if (sts.top_lt_last) begin
              state_next = S_REQ_NEW;
            end else begin
              cmd.scan_setup = 1'b1;
              cmd.range      = rrwt_pkg::RANGE_ALL;
              state_next     = S_SCAN_ALL;
            end
          end
          rrwt_pkg::OP_RECV: begin
            if (!sts.inited) begin
              state_next = S_FINISH;
            end else begin
              cmd.rcv_start = 1'b1;
              state_next    = sts.in_range ? S_RCV_MARK : S_FINISH;
            end
          end
          rrwt_pkg::OP_TIMEOUT: begin
            cmd.timeout = 1'b1;
            state_next  = S_FINISH;
          end
          rrwt_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_next = S_FINISH;
      end
      S_REQ_NEW: begin
        cmd.req_new = 1'b1;
        state_next  = S_FINISH;
      end
      S_SCAN_GAP: begin
        cmd.scan = 1'b1;
        if (sts.scan_stop) state_next = S_FINISH;
        else if (sts.scan_done) state_next = S_REQ_ALT;
      end
      S_REQ_ALT: begin
        if (sts.top_lt_last) begin
          state_next = S_REQ_NEW;
        end else begin
          cmd.scan_setup = 1'b1;
          cmd.range      = rrwt_pkg::RANGE_ALL;
          state_next     = S_SCAN_ALL;
        end
      end
      S_SCAN_ALL: begin
        cmd.scan = 1'b1;
        if (sts.scan_stop || sts.scan_done) state_next = S_FINISH;
      end
      S_RCV_MARK: begin
        cmd.rcv_mark = 1'b1;
        if (sts.bottom_le_idx) begin
          cmd.scan_setup = 1'b1;
          cmd.range      = rrwt_pkg::RANGE_BOTTOM;
          state_next     = S_SCAN_BOT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN_BOT: begin
        cmd.scan        = 1'b1;
        cmd.scan_bottom = 1'b1;
        if (sts.scan_stop || sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/rrwt_dp.sv */
// Datapath of the tracker: slot table memory, window counters, scan pipeline, result register.
// Depends on rrwt_pkg; driven by rrwt_ctrl through the command and status structs.
module rrwt_dp #(
  parameter int TABLE_DEPTH = rrwt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rrwt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrwt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [rrwt_pkg::OPCODE_W-1:0]       opcode,
  input  logic [rrwt_pkg::REC_W-1:0]          record_number,
  input  rrwt_pkg::rrwt_cmd_t                 cmd,
  output rrwt_pkg::rrwt_sts_t                 sts,
  output logic                                send_valid,
  output logic [rrwt_pkg::REC_W-1:0]          send_record,
  output logic                                send_another,
  output logic                                new_data,
  output logic                                all_received,
  output logic [rrwt_pkg::RETRY_W-1:0]        retry_count,
  output logic                                ready_flag
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > rrwt_pkg::REC_W) ? CNT_W : rrwt_pkg::REC_W) + 8;
  localparam int SW    = rrwt_pkg::STAMP_W;

  logic [rrwt_pkg::REC_W-1:0]   cfg_rc;
  logic [rrwt_pkg::WIN_W-1:0]   cfg_wm;
  logic [rrwt_pkg::REC_W-1:0]   cfg_pr;

  logic [rrwt_pkg::OPCODE_W-1:0] op_q;
  logic [rrwt_pkg::REC_W-1:0]    rec_q;

  logic [IDX_W-1:0]             last_idx;
  logic [rrwt_pkg::WIN_W-1:0]   win;
  logic [CNT_W-1:0]             top_cnt;
  logic [IDX_W-1:0]             bottom;
  logic [rrwt_pkg::WIN_W-1:0]   outst;
  logic [SW-1:0]                stamp;
  logic [rrwt_pkg::RETRY_W-1:0] tcount;
  logic                         inited;

  logic [SW-1:0]                mem [TABLE_DEPTH];
  logic [SW-1:0]                rd_data;
  logic                         mem_we;
  logic [IDX_W-1:0]             waddr;
  logic [SW-1:0]                wdata;
  logic                         mem_re;
  logic [IDX_W-1:0]             raddr;

  logic [IDX_W-1:0]             fill_ptr;
  logic [CNT_W-1:0]             issue_ptr;
  logic [IDX_W-1:0]             scan_hi;
  logic                         bot_scan;
  logic                         rd_valid;
  logic [IDX_W-1:0]             rd_idx;

  logic                         sent_valid;
  logic [IDX_W-1:0]             sent_idx;
  logic                         another;
  logic                         newd;

  logic [CMP_W-1:0] rc_w, pr_w, n_w, p_w;
  logic [CMP_W-1:0] last_w, top_w, bot_w, win_w, rec_w, sent_w;
  logic [IDX_W-1:0] rcv_idx;
  logic [IDX_W-1:0] hi_sel;
  logic [SW-1:0]    limit;
  logic             slot_rcvd;
  logic             stale_hit;
  logic             scan_left;
  logic             stale_take;
  logic             another_stale;
  logic             another_new;

  always_comb begin
    rc_w   = CMP_W'(cfg_rc);
    pr_w   = CMP_W'(cfg_pr);
    if (rc_w == '0) n_w = CMP_W'(1);
    else if (rc_w > CMP_W'(TABLE_DEPTH)) n_w = CMP_W'(TABLE_DEPTH);
    else n_w = rc_w;
    p_w    = (pr_w > n_w) ? n_w : pr_w;
    last_w = CMP_W'(last_idx);
    top_w  = CMP_W'(top_cnt);
    bot_w  = CMP_W'(bottom);
    win_w  = CMP_W'(win);
    rec_w  = CMP_W'(rec_q);
    sent_w = CMP_W'(sent_idx) + CMP_W'(1);
    rcv_idx = IDX_W'(rec_w - CMP_W'(1));
    limit         = stamp - SW'(win) + SW'(1);
    slot_rcvd     = (rd_data == rrwt_pkg::SLOT_RECEIVED);
    stale_hit     = !slot_rcvd && (rd_data < limit);
    scan_left     = (CMP_W'(issue_ptr) <= CMP_W'(scan_hi));
    another_stale = ({1'b0, outst} + 8'd1) <  {1'b0, win};
    another_new   = ({1'b0, outst} + 8'd1) <= {1'b0, win};
  end

  always_comb begin
    unique case (cmd.range)
      rrwt_pkg::RANGE_GAP: hi_sel = IDX_W'(top_w - CMP_W'(1) - win_w);
      rrwt_pkg::RANGE_ALL: hi_sel = IDX_W'(top_w - CMP_W'(1));
      default:             hi_sel = last_idx;
    endcase
    stale_take = cmd.scan && !cmd.scan_bottom && rd_valid && stale_hit;
  end

  always_comb begin
    sts.op            = op_q;
    sts.req_ok        = inited && (outst < win);
    sts.gap           = top_w > (bot_w + win_w + CMP_W'(3));
    sts.top_lt_last   = top_w <= last_w;
    sts.inited        = inited;
    sts.in_range      = (rec_q != '0) && (rec_w <= last_w + CMP_W'(1));
    sts.fill_last     = (fill_ptr == last_idx);
    sts.scan_stop     = rd_valid && (bot_scan ? !slot_rcvd : stale_hit);
    sts.scan_done     = !rd_valid && !scan_left;
    sts.bottom_le_idx = bot_w < rec_w;
  end

  // Slot table ports
  always_comb begin
    mem_we = 1'b0;
    waddr  = fill_ptr;
    wdata  = rrwt_pkg::SLOT_NOT_SENT;
    if (cmd.fill) begin
      mem_we = 1'b1;
      waddr  = fill_ptr;
      wdata  = (CMP_W'(fill_ptr) < top_w) ? rrwt_pkg::SLOT_RECEIVED : rrwt_pkg::SLOT_NOT_SENT;
    end else if (cmd.req_new) begin
      mem_we = 1'b1;
      waddr  = IDX_W'(top_cnt);
      wdata  = stamp + SW'(1);
    end else if (stale_take) begin
      mem_we = 1'b1;
      waddr  = rd_idx;
      wdata  = stamp + SW'(1);
    end else if (cmd.rcv_mark && !slot_rcvd) begin
      mem_we = 1'b1;
      waddr  = rcv_idx;
      wdata  = rrwt_pkg::SLOT_RECEIVED;
    end
    mem_re = 1'b0;
    raddr  = rcv_idx;
    if (cmd.scan && scan_left) begin
      mem_re = 1'b1;
      raddr  = issue_ptr[IDX_W-1:0];
    end else if (cmd.rcv_start) begin
      mem_re = 1'b1;
      raddr  = rcv_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rc   <= rrwt_pkg::RECORD_COUNT_RST;
      cfg_wm   <= rrwt_pkg::WINDOW_MAX_RST;
      cfg_pr   <= rrwt_pkg::PREREAD_COUNT_RST;
      last_idx <= IDX_W'(TABLE_DEPTH - 1);
      win      <= rrwt_pkg::WINDOW_MAX_RST;
      top_cnt  <= '0;
      bottom   <= '0;
      outst    <= '0;
      stamp    <= '0;
      tcount   <= '0;
      inited   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          rrwt_pkg::CFG_RECORD_COUNT:  cfg_rc <= cfg_data;
          rrwt_pkg::CFG_WINDOW_MAX:    cfg_wm <= cfg_data[rrwt_pkg::WIN_W-1:0];
          rrwt_pkg::CFG_PREREAD_COUNT: cfg_pr <= cfg_data;
          default: ;
        endcase
      end
      rd_valid <= cmd.scan && scan_left;
      if (cmd.init_start) begin
        last_idx <= IDX_W'(n_w - CMP_W'(1));
        win      <= cfg_wm;
        top_cnt  <= CNT_W'(p_w);
        bottom   <= (p_w == '0) ? '0 : IDX_W'(p_w - CMP_W'(1));
        outst    <= '0;
        stamp    <= '0;
        tcount   <= '0;
        inited   <= 1'b1;
      end else if (cmd.req_new) begin
        stamp   <= stamp + SW'(1);
        top_cnt <= top_cnt + CNT_W'(1);
        outst   <= outst + 7'd1;
      end else if (stale_take) begin
        stamp <= stamp + SW'(1);
        outst <= outst + 7'd1;
      end else if (cmd.rcv_start) begin
        tcount <= '0;
        if (outst != '0) outst <= outst - 7'd1;
      end else if (cmd.timeout) begin
        outst <= '0;
        stamp <= stamp + SW'(win);
        if (tcount != 8'hFF) tcount <= tcount + 8'd1;
      end else if (cmd.clear) begin
        tcount <= '0;
      end else if (cmd.scan && cmd.scan_bottom && rd_valid && slot_rcvd) begin
        bottom <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= opcode;
      rec_q      <= record_number;
      sent_valid <= 1'b0;
      another    <= 1'b0;
      newd       <= 1'b0;
    end
    if (cmd.init_start) fill_ptr <= '0;
    else if (cmd.fill) fill_ptr <= fill_ptr + IDX_W'(1);
    if (cmd.scan_setup) begin
      issue_ptr <= CNT_W'(bottom);
      scan_hi   <= hi_sel;
      bot_scan  <= (cmd.range == rrwt_pkg::RANGE_BOTTOM);
    end else if (cmd.scan && scan_left) begin
      issue_ptr <= issue_ptr + CNT_W'(1);
    end
    rd_idx <= issue_ptr[IDX_W-1:0];
    if (cmd.req_new) begin
      sent_valid <= 1'b1;
      sent_idx   <= IDX_W'(top_cnt);
      another    <= another_new;
    end else if (stale_take) begin
      sent_valid <= 1'b1;
      sent_idx   <= rd_idx;
      another    <= another_stale;
    end
    if (cmd.rcv_mark) newd <= !slot_rcvd;
    if (cmd.out_load) begin
      send_valid   <= sent_valid;
      send_record  <= sent_valid ? sent_w[rrwt_pkg::REC_W-1:0] : '0;
      send_another <= sent_valid && another;
      new_data     <= newd;
      all_received <= inited && (bottom == last_idx);
      retry_count  <= tcount;
      ready_flag   <= inited;
    end
  end

endmodule

/* rtl/core/record_request_window_tracker_top.sv */
// Flow: timeout, clear and refused steps answer directly; init fills the slot table; next may
// make a gap pass and then a full pass over the table, or issue a new record; receive marks its
// slot and may scan up from the bottom. Throughput: one transaction at a time, set by the table
// scan (1 entry/cycle), and held while a response stalls. Reset: synchronous; configuration,
// counters, state and handshake clear, the result fields do not, and the slot table is undefined
// until init writes it.
module record_request_window_tracker_top #(
  parameter int TABLE_DEPTH = rrwt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rrwt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrwt_pkg::CFG_DATA_W-1:0] cfg_data,
  rrwt_req_if.sink                        req,
  rrwt_rsp_if.source                      rsp
);

  rrwt_pkg::rrwt_cmd_t cmd;
  rrwt_pkg::rrwt_sts_t sts;

  rrwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrwt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (req.opcode),
    .record_number (req.record_number),
    .cmd           (cmd),
    .sts           (sts),
    .send_valid    (rsp.send_valid),
    .send_record   (rsp.send_record),
    .send_another  (rsp.send_another),
    .new_data      (rsp.new_data),
    .all_received  (rsp.all_received),
    .retry_count   (rsp.retry_count),
    .ready_flag    (rsp.ready_flag)
  );

endmodule

/* rtl/core/rrwt_checker.sv */
// Port-level checks on the tracker's request and response transactions.
// Depends on rrwt_pkg; bound to record_request_window_tracker_top below.
module rrwt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_send_valid,
  input logic [rrwt_pkg::REC_W-1:0]    rsp_send_record,
  input logic                          rsp_send_another,
  input logic                          rsp_new_data,
  input logic [rrwt_pkg::RETRY_W-1:0]  rsp_retry_count,
  input logic                          rsp_ready_flag
);

  a_no_send_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_send_valid |-> rsp_send_record == '0 && !rsp_send_another)
    else $error("response without request carries a record or send_another");

  a_send_needs_init: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_send_valid |-> rsp_ready_flag && rsp_send_record != '0)
    else $error("request issued before init or with record zero");

  a_new_data_clears_retry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_new_data |-> rsp_ready_flag && rsp_retry_count == '0)
    else $error("new data reported with retry count left standing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transaction taken while one is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_send_record)
                               && $stable(rsp_retry_count))
    else $error("stalled response dropped or changed");

endmodule

bind record_request_window_tracker_top rrwt_checker u_rrwt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_send_valid   (rsp.send_valid),
  .rsp_send_record  (rsp.send_record),
  .rsp_send_another (rsp.send_another),
  .rsp_new_data     (rsp.new_data),
  .rsp_retry_count  (rsp.retry_count),
  .rsp_ready_flag   (rsp.ready_flag)
);

/* dv/record_request_window_tracker_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for record_request_window_tracker_top: directed table, then random
// phases of fetch traffic with spare opcodes and out-of-range records, checked against a window model.
// Depends on rrwt_pkg and the rrwt_req_if / rrwt_rsp_if channel interfaces.
module record_request_window_tracker_top_tb;

  localparam int DEPTH        = rrwt_pkg::TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 580;
  localparam logic [rrwt_pkg::OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [rrwt_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [rrwt_pkg::OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic                         send_valid;
    logic [rrwt_pkg::REC_W-1:0]   send_record;
    logic                         send_another;
    logic                         new_data;
    logic                         all_received;
    logic [rrwt_pkg::RETRY_W-1:0] retry_count;
    logic                         ready_flag;
  } reply_t;

  typedef struct {
    logic [rrwt_pkg::OPCODE_W-1:0] op;
    logic [rrwt_pkg::REC_W-1:0]    rec;
    bit                            typed;
    reply_t                        want;
  } drill_row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [rrwt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rrwt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            rsp_take = 1'b0;

  rrwt_req_if req_ch ();
  rrwt_rsp_if rsp_ch ();

  assign rsp_ch.ready = rsp_take;

  record_request_window_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  logic [rrwt_pkg::STAMP_W-1:0] slot_tab [DEPTH];
  logic [rrwt_pkg::STAMP_W-1:0] stamp;
  int                           top_idx;
  int                           bot_idx;
  int                           in_flight;
  int                           retries;
  int                           last_idx;
  int                           win_latch;
  bit                           inited;
  logic [rrwt_pkg::REC_W-1:0]   reg_count;
  logic [rrwt_pkg::WIN_W-1:0]   reg_window;
  logic [rrwt_pkg::REC_W-1:0]   reg_preread;

  reply_t                     awaited_replies [$];
  logic [rrwt_pkg::REC_W-1:0] asked_records [$];
  int                         errors = 0;
  int                         burst_left = 0;
  int                         items_sent = 0;
  int                         idle_cycles = 0;
  int                         mode = 0;
  int                         mode_left = 0;
  int                         pattern_cnt = 0;

  function automatic int resend_stale(int lo, int hi);
    logic [rrwt_pkg::STAMP_W-1:0] lim;
    int i;
    lim = stamp - (rrwt_pkg::STAMP_W'(win_latch) - 32'd1);
    for (i = lo; i <= hi; i++) begin
      if (i < 0 || i > last_idx) continue;
      if (slot_tab[i] != rrwt_pkg::SLOT_RECEIVED && slot_tab[i] < lim) begin
        stamp = stamp + 32'd1;
        slot_tab[i] = stamp;
        in_flight++;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic reply_t predict_window_step(logic [rrwt_pkg::OPCODE_W-1:0] op,
                                                 logic [rrwt_pkg::REC_W-1:0] rec);
    int     sent;
    int     idx;
    int     n;
    int     p;
    int     i;
    bit     another;
    bit     newd;
    reply_t r;
    sent    = -1;
    another = 1'b0;
    newd    = 1'b0;
    case (op)
      rrwt_pkg::OP_INIT: begin
        n = int'(reg_count);
        p = int'(reg_preread);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        if (p > n) p = n;
        retries  = 0;
        inited   = 1'b1;
        last_idx = n - 1;
        top_idx  = -1;
        bot_idx  = 0;
        for (i = 0; i < n; i++) slot_tab[i] = rrwt_pkg::SLOT_NOT_SENT;
        for (i = 0; i < p; i++) slot_tab[i] = rrwt_pkg::SLOT_RECEIVED;
        if (p > 0) begin
          top_idx = p - 1;
          bot_idx = p - 1;
        end
        in_flight = 0;
        win_latch = int'(reg_window);
        stamp     = '0;
      end
      rrwt_pkg::OP_NEXT: begin
        if (inited && in_flight < win_latch) begin
          if (top_idx - bot_idx > win_latch + 2)
            sent = resend_stale(bot_idx, top_idx - win_latch);
          if (sent >= 0) begin
            another = in_flight < win_latch;
          end else if (top_idx < last_idx) begin
            stamp = stamp + 32'd1;
            top_idx++;
            slot_tab[top_idx] = stamp;
            in_flight++;
            sent    = top_idx;
            another = in_flight <= win_latch;
          end else begin
            sent = resend_stale(bot_idx, top_idx);
            if (sent >= 0) another = in_flight < win_latch;
          end
        end
      end
      rrwt_pkg::OP_RECV: begin
        if (inited) begin
          idx     = int'(rec) - 1;
          retries = 0;
          if (in_flight > 0) in_flight--;
          if (idx >= 0 && idx <= last_idx) begin
            if (slot_tab[idx] != rrwt_pkg::SLOT_RECEIVED) begin
              slot_tab[idx] = rrwt_pkg::SLOT_RECEIVED;
              newd = 1'b1;
            end
            if (bot_idx <= idx) begin
              for (i = bot_idx; i <= last_idx; i++) begin
                if (slot_tab[i] != rrwt_pkg::SLOT_RECEIVED) break;
                bot_idx = i;
              end
            end
          end
        end
      end
      rrwt_pkg::OP_TIMEOUT: begin
        in_flight = 0;
        stamp     = stamp + rrwt_pkg::STAMP_W'(win_latch);
        if (retries < 255) retries++;
      end
      rrwt_pkg::OP_CLEAR: retries = 0;
      default: ;
    endcase
    r.send_valid   = sent >= 0;
    r.send_record  = (sent >= 0) ? rrwt_pkg::REC_W'(sent + 1) : '0;
    r.send_another = (sent >= 0) && another;
    r.new_data     = newd;
    r.all_received = inited && (bot_idx == last_idx);
    r.retry_count  = rrwt_pkg::RETRY_W'(retries);
    r.ready_flag   = inited;
    return r;
  endfunction

  function automatic reply_t mk_reply(logic sv, logic [rrwt_pkg::REC_W-1:0] rec, logic another,
                                      logic newd, logic allr,
                                      logic [rrwt_pkg::RETRY_W-1:0] retry, logic rdy);
    reply_t r;
    r = '{sv, rec, another, newd, allr, retry, rdy};
    return r;
  endfunction

  function automatic drill_row_t row(logic [rrwt_pkg::OPCODE_W-1:0] op,
                                     logic [rrwt_pkg::REC_W-1:0] rec, bit typed,
                                     reply_t want);
    drill_row_t d;
    d.op    = op;
    d.rec   = rec;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  task automatic put_item(input logic [rrwt_pkg::OPCODE_W-1:0] op,
                          input logic [rrwt_pkg::REC_W-1:0] rec,
                          input bit typed, input reply_t want);
    reply_t forecast;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.record_number <= rec;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    forecast = predict_window_step(op, rec);
    if (op == rrwt_pkg::OP_INIT) asked_records.delete();
    if (forecast.send_valid) asked_records.push_back(forecast.send_record);
    awaited_replies.push_back(typed ? want : forecast);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [rrwt_pkg::REC_W-1:0] count,
                            input logic [rrwt_pkg::WIN_W-1:0] win,
                            input logic [rrwt_pkg::REC_W-1:0] pre, input logic [2:0] mask);
    if (mask[0]) begin
      cfg_write <= 1'b1;
      cfg_index <= rrwt_pkg::CFG_RECORD_COUNT;
      cfg_data  <= count;
      @(posedge clk);
      reg_count = count;
    end
    if (mask[1]) begin
      cfg_write <= 1'b1;
      cfg_index <= rrwt_pkg::CFG_WINDOW_MAX;
      cfg_data  <= rrwt_pkg::CFG_DATA_W'(win);
      @(posedge clk);
      reg_window = win;
    end
    if (mask[2]) begin
      cfg_write <= 1'b1;
      cfg_index <= rrwt_pkg::CFG_PREREAD_COUNT;
      cfg_data  <= pre;
      @(posedge clk);
      reg_preread = pre;
    end
    cfg_write <= 1'b0;
  endtask

  task automatic pick_item(output logic [rrwt_pkg::OPCODE_W-1:0] op,
                           output logic [rrwt_pkg::REC_W-1:0] rec);
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    rec  = rrwt_pkg::REC_W'($urandom_range(0, 2047));
    if (roll < 45) begin
      op = rrwt_pkg::OP_NEXT;
    end else if (roll < 80) begin
      op = rrwt_pkg::OP_RECV;
      if (asked_records.size() != 0 && $urandom_range(0, 4) != 0) begin
        k   = $urandom_range(0, asked_records.size() - 1);
        rec = asked_records[k];
        asked_records.delete(k);
      end else begin
        rec = rrwt_pkg::REC_W'($urandom_range(1, last_idx + 1));
      end
    end else if (roll < 86) begin
      op = rrwt_pkg::OP_TIMEOUT;
    end else if (roll < 89) begin
      op = rrwt_pkg::OP_CLEAR;
    end else if (roll < 91) begin
      op = rrwt_pkg::OP_INIT;
    end else if (roll < 94) begin
      op = rrwt_pkg::OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else begin
      op = rrwt_pkg::OP_RECV;
      case ($urandom_range(0, 2))
        0: rec = '0;
        1: rec = rrwt_pkg::REC_W'($urandom_range(last_idx + 2, 2047));
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen = '{rsp_ch.send_valid, rsp_ch.send_record, rsp_ch.send_another, rsp_ch.new_data,
               rsp_ch.all_received, rsp_ch.retry_count, rsp_ch.ready_flag};
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, seen);
      end else begin
        want = awaited_replies.pop_front();
        check_field("send_valid", 32'(want.send_valid), 32'(seen.send_valid));
        check_field("send_record", 32'(want.send_record), 32'(seen.send_record));
        check_field("send_another", 32'(want.send_another), 32'(seen.send_another));
        check_field("new_data", 32'(want.new_data), 32'(seen.new_data));
        check_field("all_received", 32'(want.all_received), 32'(seen.all_received));
        check_field("retry_count", 32'(want.retry_count), 32'(seen.retry_count));
        check_field("ready_flag", 32'(want.ready_flag), 32'(seen.ready_flag));
      end
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode      <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    pattern_cnt <= pattern_cnt + 1;
    case (mode)
      0: rsp_take <= 1'b1;
      1: rsp_take <= $urandom_range(0, 9) < 6;
      default: rsp_take <= (pattern_cnt % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("record_request_window_tracker_top_tb failed");
      $finish;
    end
  end

  initial begin
    drill_row_t                    drill [$];
    int                            phase;
    int                            len;
    int                            roll;
    logic [rrwt_pkg::REC_W-1:0]    cnt;
    logic [rrwt_pkg::REC_W-1:0]    pre;
    logic [rrwt_pkg::WIN_W-1:0]    win;
    logic [2:0]                    mask;
    logic [rrwt_pkg::OPCODE_W-1:0] op;
    logic [rrwt_pkg::REC_W-1:0]    rec;

    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= rrwt_pkg::CFG_RECORD_COUNT;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= rrwt_pkg::OP_CLEAR;
    req_ch.record_number <= '0;

    top_idx     = -1;
    bot_idx     = 0;
    in_flight   = 0;
    stamp       = '0;
    retries     = 0;
    inited      = 1'b0;
    last_idx    = DEPTH - 1;
    win_latch   = int'(rrwt_pkg::WINDOW_MAX_RST);
    reg_count   = rrwt_pkg::RECORD_COUNT_RST;
    reg_window  = rrwt_pkg::WINDOW_MAX_RST;
    reg_preread = rrwt_pkg::PREREAD_COUNT_RST;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 0, 0)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd1, 1, mk_reply(0, 0, 0, 0, 0, 0, 0)));
    drill.push_back(row(rrwt_pkg::OP_TIMEOUT, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 1, 0)));
    drill.push_back(row(rrwt_pkg::OP_TIMEOUT, 11'd2047, 1, mk_reply(0, 0, 0, 0, 0, 2, 0)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd3, 1, mk_reply(0, 0, 0, 0, 0, 2, 0)));
    drill.push_back(row(rrwt_pkg::OP_CLEAR, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 0, 0)));
    drill.push_back(row(OP_SPARE_LO, 11'd2047, 1, mk_reply(0, 0, 0, 0, 0, 0, 0)));
    drill.push_back(row(OP_SPARE_HI, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 0, 0)));
    drill.push_back(row(rrwt_pkg::OP_INIT, 11'h555, 1, mk_reply(0, 0, 0, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'h2aa, 1, mk_reply(1, 1, 1, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd1, 1, mk_reply(0, 0, 0, 1, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd1, 1, mk_reply(0, 0, 0, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd2047, 1, mk_reply(0, 0, 0, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd1025, 1, mk_reply(0, 0, 0, 0, 0, 0, 1)));
    drill.push_back(row(rrwt_pkg::OP_TIMEOUT, 11'd0, 1, mk_reply(0, 0, 0, 0, 0, 1, 1)));
    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'd0, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd1024, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'd0, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'd0, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_NEXT, 11'd0, 0, '0));
    drill.push_back(row(OP_SPARE_MID, 11'd1365, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_CLEAR, 11'd0, 0, '0));
    drill.push_back(row(rrwt_pkg::OP_RECV, 11'd2, 0, '0));

    foreach (drill[i]) put_item(drill[i].op, drill[i].rec, drill[i].typed, drill[i].want);
    wait_drained();

    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin cnt = 11'd1;    win = 7'd1;  pre = 11'd0;    end
        1: begin cnt = 11'd1024; win = 7'd64; pre = 11'd1024; end
        2: begin cnt = 11'd3;    win = 7'd1;  pre = 11'd1024; end
        3: begin cnt = 11'd2;    win = 7'd2;  pre = 11'd0;    end
        default: begin
          roll = $urandom_range(0, 99);
          cnt  = (roll < 10) ? 11'd1024 : (roll < 20) ? 11'd1 :
                 rrwt_pkg::REC_W'($urandom_range(2, 48));
          roll = $urandom_range(0, 99);
          win  = (roll < 15) ? 7'd1 : (roll < 25) ? 7'd64 :
                 rrwt_pkg::WIN_W'($urandom_range(1, 16));
          roll = $urandom_range(0, 99);
          if (roll < 50)      pre = '0;
          else if (roll < 65) pre = cnt;
          else if (roll < 72) pre = 11'd1024;
          else                pre = rrwt_pkg::REC_W'($urandom_range(0, cnt));
        end
      endcase
      mask = (phase < 4) ? 3'b111 : 3'($urandom_range(0, 7));
      write_regs(cnt, win, pre, mask);
      if (phase < 4 || $urandom_range(0, 7) != 0)
        put_item(rrwt_pkg::OP_INIT, rrwt_pkg::REC_W'($urandom_range(0, 2047)), 1'b0, '0);
      if (phase == 3) begin
        put_item(rrwt_pkg::OP_NEXT, '0, 1'b0, '0);
        repeat (257)
          put_item(rrwt_pkg::OP_TIMEOUT, rrwt_pkg::REC_W'($urandom_range(0, 2047)), 1'b0, '0);
        put_item(rrwt_pkg::OP_NEXT, '0, 1'b0, '0);
        put_item(rrwt_pkg::OP_RECV, 11'd1, 1'b0, '0);
        put_item(rrwt_pkg::OP_RECV, 11'd2, 1'b0, '0);
        put_item(rrwt_pkg::OP_CLEAR, '0, 1'b0, '0);
      end else begin
        len = (last_idx == DEPTH - 1) ? $urandom_range(8, 20) : $urandom_range(12, 50);
        repeat (len) begin
          pick_item(op, rec);
          put_item(op, rec, 1'b0, '0);
          if ($urandom_range(0, 49) == 0) wait_drained();
        end
      end
      wait_drained();
      phase++;
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("record_request_window_tracker_top_tb passed");
    else
      $display("record_request_window_tracker_top_tb failed");
    $finish;
  end

endmodule
